@@ design/gwl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwl_pkg
// Shared types, constants and pen arithmetic for the glyph layout unit.
// ----------------------------------------------------------------------------
package gwl_pkg;

    // field widths
    localparam int X_W    = 10;
    localparam int Y_W    = 16;
    localparam int CODE_W = 8;
    localparam int TOPY_W = 12;

    // parameter defaults
    localparam int FRAME_WIDTH_DEF     = 320;
    localparam int MAX_LINE_GLYPHS_DEF = 37;
    localparam int GLYPH_LIMIT_DEF     = 256;

    // queue depths
    localparam int CMD_Q_DEPTH = 4;
    localparam int RES_Q_DEPTH = 2;

    // layout constants
    localparam logic [X_W-1:0]    LEFT_X      = 10'd10;
    localparam logic [X_W-1:0]    PEN_X_MAX   = 10'd1023;
    localparam logic [Y_W-1:0]    PEN_Y_MAX   = 16'hFFFF;
    localparam logic [X_W-1:0]    CELL_X      = 10'd8;
    localparam logic [Y_W-1:0]    CELL_Y      = 16'd8;
    localparam logic [CODE_W-1:0] CODE_NL     = 8'h0A;
    localparam logic [CODE_W-1:0] CODE_SP     = 8'h20;
    localparam logic [TOPY_W-1:0] TOP_Y_RESET = 12'd10;

    // byte classes
    localparam logic [1:0] K_WORD    = 2'd0;
    localparam logic [1:0] K_BLANK   = 2'd1;
    localparam logic [1:0] K_NEWLINE = 2'd2;

    // classified request from the front part
    typedef struct packed {
        logic [1:0]        kind;
        logic [CODE_W-1:0] code;
        logic              last;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [CODE_W-1:0] code;
        logic              valid;
        logic              run_last;
        logic              string_end;
    } t_res;

    // pen x one cell to the right, saturating
    function automatic logic [X_W-1:0] step_x(input logic [X_W-1:0] x);
        step_x = (x > PEN_X_MAX - CELL_X) ? PEN_X_MAX : x + CELL_X;
    endfunction

    // pen y one line down, saturating
    function automatic logic [Y_W-1:0] step_y(input logic [Y_W-1:0] y);
        step_y = (y > PEN_Y_MAX - CELL_Y) ? PEN_Y_MAX : y + CELL_Y;
    endfunction

endpackage

@@ design/gwl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 37
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/gwl_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwl_fifo
// Small register queue with first-word fall-through head.
// ----------------------------------------------------------------------------
module gwl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_rdata
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_data[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and count update
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wptr] <= i_wdata;
        end
    end
endmodule

@@ design/gwl_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwl_front
// Accepts caption bytes and classifies them as word byte, blank or newline.
// ----------------------------------------------------------------------------
module gwl_front import gwl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CODE_W-1:0] i_char_code,
    input  logic              i_last_char,
    output logic              o_cmd_push,
    output t_cmd              o_cmd,
    input  logic              i_cmd_full
);
    logic r_cmd_v, n_cmd_v;
    t_cmd r_cmd, n_cmd;
    logic take;

    assign full       = r_cmd_v && i_cmd_full;
    assign take       = push && !full;
    assign o_cmd_push = r_cmd_v;
    assign o_cmd      = r_cmd;

    // classify and stage one request
    always_comb begin
        n_cmd_v = r_cmd_v && i_cmd_full;
        n_cmd   = r_cmd;
        if (take) begin
            n_cmd_v    = 1'b1;
            n_cmd.code = i_char_code;
            n_cmd.last = i_last_char;
            if (i_char_code == CODE_NL) begin
                n_cmd.kind = K_NEWLINE;
            end else if (i_char_code <= CODE_SP) begin
                n_cmd.kind = K_BLANK;
            end else begin
                n_cmd.kind = K_WORD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_v <= 1'b0;
        end else begin
            r_cmd_v <= n_cmd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end
endmodule

@@ design/gwl_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwl_back
// Executes classified requests: word buffering, wrap decision, glyph output.
// ----------------------------------------------------------------------------
module gwl_back import gwl_pkg::*; #(
    parameter int FRAME_WIDTH     = FRAME_WIDTH_DEF,
    parameter int MAX_LINE_GLYPHS = MAX_LINE_GLYPHS_DEF,
    parameter int GLYPH_LIMIT     = GLYPH_LIMIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [TOPY_W-1:0] i_text_top_y,
    input  logic              i_cmd_empty,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output t_res              o_res
);
    localparam int WL_W  = $clog2(MAX_LINE_GLYPHS + 1);
    localparam int AW    = $clog2(MAX_LINE_GLYPHS);
    localparam int GP_W  = $clog2(GLYPH_LIMIT + 1);
    localparam int SUM_W = ((WL_W + 3 > X_W) ? WL_W + 3 : X_W) + 1;
    localparam int RIGHT_LIMIT = FRAME_WIDTH - 10;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRE   = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_ACT   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]      r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    logic            r_in_str, n_in_str;
    logic [X_W-1:0]  r_pen_x, n_pen_x;
    logic [Y_W-1:0]  r_pen_y, n_pen_y;
    logic [WL_W-1:0] r_wlen, n_wlen;
    logic [GP_W-1:0] r_placed, n_placed;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_too_long, n_too_long;
    logic            r_final, n_final;
    logic            r_hold_v, n_hold_v;
    t_res            r_hold, n_hold;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [CODE_W-1:0] ram_rdata;

    logic [SUM_W-1:0] right_edge;
    logic             wrap;
    logic             emit_ok;
    logic             go;
    logic             last_g;

    // word buffer
    gwl_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MAX_LINE_GLYPHS)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_cmd.code),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // wrap test and glyph step conditions
    assign right_edge = SUM_W'(r_pen_x) + (SUM_W'(r_wlen) << 3);
    assign wrap       = (r_too_long || right_edge > SUM_W'(RIGHT_LIMIT)) && (r_pen_x > LEFT_X);
    assign emit_ok    = r_placed < GP_W'(GLYPH_LIMIT);
    assign go         = !(emit_ok && r_hold_v && i_res_full);
    assign last_g     = (WL_W'(r_idx) + WL_W'(1)) == r_wlen;
    assign ram_waddr  = r_wlen[AW-1:0];

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_in_str   = r_in_str;
        n_pen_x    = r_pen_x;
        n_pen_y    = r_pen_y;
        n_wlen     = r_wlen;
        n_placed   = r_placed;
        n_idx      = r_idx;
        n_too_long = r_too_long;
        n_final    = r_final;
        n_hold_v   = r_hold_v;
        n_hold     = r_hold;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = r_hold;
        ram_we     = 1'b0;
        ram_raddr  = '0;
        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    if (!r_in_str) begin
                        n_pen_x  = LEFT_X;
                        n_pen_y  = Y_W'(i_text_top_y);
                        n_in_str = 1'b1;
                    end
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                // pending word ends, or a full piece must go out first
                if (((r_cmd.kind != K_WORD) || (r_wlen == WL_W'(MAX_LINE_GLYPHS)))
                        && (r_wlen != '0)) begin
                    n_too_long = (r_cmd.kind == K_WORD);
                    n_final    = 1'b0;
                    n_state    = S_SETUP;
                end else begin
                    n_state = S_ACT;
                end
            end
            S_SETUP: begin
                if (wrap) begin
                    n_pen_x = LEFT_X;
                    n_pen_y = step_y(r_pen_y);
                end
                n_idx   = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                ram_raddr = (go && !last_g) ? r_idx + 1'b1 : r_idx;
                if (go) begin
                    if (emit_ok) begin
                        o_res_push       = r_hold_v;
                        n_hold_v         = 1'b1;
                        n_hold.x         = r_pen_x;
                        n_hold.y         = r_pen_y;
                        n_hold.code      = ram_rdata;
                        n_hold.valid     = 1'b1;
                        n_hold.run_last  = 1'b0;
                        n_hold.string_end = 1'b0;
                        n_placed         = r_placed + 1'b1;
                    end
                    n_pen_x = step_x(r_pen_x);
                    if (last_g) begin
                        n_wlen  = '0;
                        n_state = r_final ? S_FIN : S_ACT;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_ACT: begin
                n_state = S_FIN;
                case (r_cmd.kind)
                    K_NEWLINE: begin
                        n_pen_x = LEFT_X;
                        n_pen_y = step_y(r_pen_y);
                    end
                    K_BLANK: begin
                        n_pen_x = step_x(r_pen_x);
                    end
                    default: begin
                        ram_we = 1'b1;
                        n_wlen = r_wlen + 1'b1;
                        if (r_cmd.last) begin
                            n_final    = 1'b1;
                            n_too_long = 1'b0;
                            n_state    = S_SETUP;
                        end
                    end
                endcase
            end
            S_FIN: begin
                // mark the final result of this request
                o_res.run_last   = 1'b1;
                o_res.string_end = r_cmd.last;
                if (!r_hold_v) begin
                    o_res.x     = '0;
                    o_res.y     = '0;
                    o_res.code  = '0;
                    o_res.valid = 1'b0;
                end
                if (!((r_hold_v || r_cmd.last) && i_res_full)) begin
                    o_res_push = r_hold_v || r_cmd.last;
                    n_hold_v   = 1'b0;
                    if (r_cmd.last) begin
                        n_pen_x  = LEFT_X;
                        n_pen_y  = Y_W'(i_text_top_y);
                        n_wlen   = '0;
                        n_placed = '0;
                        n_in_str = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_str <= 1'b0;
            r_pen_x  <= LEFT_X;
            r_pen_y  <= Y_W'(TOP_Y_RESET);
            r_wlen   <= '0;
            r_placed <= '0;
            r_hold_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_str <= n_in_str;
            r_pen_x  <= n_pen_x;
            r_pen_y  <= n_pen_y;
            r_wlen   <= n_wlen;
            r_placed <= n_placed;
            r_hold_v <= n_hold_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_too_long <= n_too_long;
        r_final    <= n_final;
        r_hold     <= n_hold;
    end
endmodule

@@ design/greedy_word_wrap_glyph_layout_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_word_wrap_glyph_layout_unit
// Lays out caption bytes as 8x8 glyph tiles with greedy word wrap.
// ----------------------------------------------------------------------------
// path: a byte is registered in the front stage, then passes the request queue to
//   the sequencer; its results pass the result queue on their way to the ports
// sequence: the sequencer takes, decodes, acts on and finishes each byte before it
//   takes the next; placing a word adds a setup step and an emit step per glyph
// stalls: a full result queue holds the sequencer, a full request queue the input
// reset: synchronous, clears queues and pen; text_top_y returns to 10
module greedy_word_wrap_glyph_layout_unit import gwl_pkg::*; #(
    parameter int FRAME_WIDTH     = FRAME_WIDTH_DEF,
    parameter int MAX_LINE_GLYPHS = MAX_LINE_GLYPHS_DEF,
    parameter int GLYPH_LIMIT     = GLYPH_LIMIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TOPY_W-1:0] i_cfg_wdata,
    input  logic              push,
    output logic              full,
    input  logic [CODE_W-1:0] i_char_code,
    input  logic              i_last_char,
    output logic              empty,
    input  logic              pop,
    output logic [X_W-1:0]    o_glyph_x,
    output logic [Y_W-1:0]    o_glyph_y,
    output logic [CODE_W-1:0] o_glyph_code,
    output logic              o_glyph_valid,
    output logic              o_run_last,
    output logic              o_string_end
);
    logic [TOPY_W-1:0] r_text_top_y;

    logic cmd_push, cmd_full, cmd_empty, cmd_pop;
    t_cmd cmd_in, cmd_out;
    logic res_push, res_full;
    t_res res_in, res_out;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_top_y <= TOP_Y_RESET;
        end else if (i_cfg_we) begin
            r_text_top_y <= i_cfg_wdata;
        end
    end

    // front: accept and classify
    gwl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in),
        .i_cmd_full  (cmd_full)
    );

    // request queue between front and back
    gwl_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_wdata (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_rdata (cmd_out)
    );

    // back: layout sequencer
    gwl_back #(
        .FRAME_WIDTH     (FRAME_WIDTH),
        .MAX_LINE_GLYPHS (MAX_LINE_GLYPHS),
        .GLYPH_LIMIT     (GLYPH_LIMIT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text_top_y (r_text_top_y),
        .i_cmd_empty  (cmd_empty),
        .i_cmd        (cmd_out),
        .o_cmd_pop    (cmd_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res_in)
    );

    // result queue
    gwl_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_rdata (res_out)
    );

    assign o_glyph_x     = res_out.x;
    assign o_glyph_y     = res_out.y;
    assign o_glyph_code  = res_out.code;
    assign o_glyph_valid = res_out.valid;
    assign o_run_last    = res_out.run_last;
    assign o_string_end  = res_out.string_end;
endmodule

@@ design/gwl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwl_checker
// Port-level checks on the result stream of the glyph layout unit.
// ----------------------------------------------------------------------------
module gwl_checker import gwl_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              empty,
    input logic              pop,
    input logic [X_W-1:0]    o_glyph_x,
    input logic [Y_W-1:0]    o_glyph_y,
    input logic [CODE_W-1:0] o_glyph_code,
    input logic              o_glyph_valid,
    input logic              o_run_last,
    input logic              o_string_end
);
    // caption end is always the last result of its request
    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_string_end) |-> o_run_last)
        else $error("string_end without run_last");

    // an empty end marker carries zero fields and closes the caption
    a_marker_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_glyph_valid) |->
        (o_string_end && o_glyph_x == '0 && o_glyph_y == '0 && o_glyph_code == '0))
        else $error("malformed end marker");

    // a placed glyph never sits left of the margin
    a_x_margin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_glyph_valid) |-> (o_glyph_x >= LEFT_X))
        else $error("glyph left of margin");

    // a waiting result stays while not popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped while stalled");
endmodule

bind greedy_word_wrap_glyph_layout_unit gwl_checker u_gwl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_glyph_x     (o_glyph_x),
    .o_glyph_y     (o_glyph_y),
    .o_glyph_code  (o_glyph_code),
    .o_glyph_valid (o_glyph_valid),
    .o_run_last    (o_run_last),
    .o_string_end  (o_string_end)
);
